// ===== rtl/usbsrr_pkg.sv =====
// ----------------------------------------------------------------------------
// usbsrr_pkg
// Request keys, response codes and the result record of the standard
// request responder.
// ----------------------------------------------------------------------------
package usbsrr_pkg;

	// Request keys: {bRequest, bmRequestType}
	localparam logic [15:0] KEY_SET_ADDRESS     = 16'h0500;
	localparam logic [15:0] KEY_SET_CONFIG      = 16'h0900;
	localparam logic [15:0] KEY_GET_CONFIG      = 16'h0880;
	localparam logic [15:0] KEY_GET_STATUS_DEV  = 16'h0080;
	localparam logic [15:0] KEY_GET_STATUS_EP   = 16'h0082;
	localparam logic [15:0] KEY_SET_FEATURE_EP  = 16'h0302;
	localparam logic [15:0] KEY_CLEAR_FEATURE   = 16'h0102;
	localparam logic [15:0] KEY_GET_DESC_DEV    = 16'h0680;
	localparam logic [15:0] KEY_GET_DESC_IF     = 16'h0681;
	localparam logic [15:0] KEY_SET_INTERFACE   = 16'h0B01;
	localparam logic [15:0] KEY_GET_INTERFACE   = 16'h0A81;

	// Endpoint number field of wIndex
	localparam logic [6:0]  EP_NUM_MASK         = 7'h7F;

	// Response codes
	localparam logic [1:0]  RESP_STALL          = 2'd0;
	localparam logic [1:0]  RESP_ACK            = 2'd1;
	localparam logic [1:0]  RESP_DATA           = 2'd2;
	localparam logic [1:0]  RESP_DESC           = 2'd3;

	// Reply byte counts
	localparam logic [1:0]  LEN_NONE            = 2'd0;
	localparam logic [1:0]  LEN_ONE             = 2'd1;
	localparam logic [1:0]  LEN_TWO             = 2'd2;

	// One result record
	typedef struct packed {
		logic [1:0]  response;
		logic [1:0]  reply_length;
		logic [7:0]  reply_first;
		logic [7:0]  reply_second;
		logic        address_load;
		logic [6:0]  device_address;
		logic        config_reset;
		logic [15:0] descriptor_select;
		logic [15:0] descriptor_language;
		logic [15:0] descriptor_limit;
	} result_t;

endpackage

// ===== rtl/usb_standard_request_responder.sv =====
// ----------------------------------------------------------------------------
// usb_standard_request_responder
// Decodes one USB setup packet per request and answers the standard
// requests, keeping configuration, alternate setting and endpoint halts.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ------------------------------------------
//  input     in_valid / in_ready    request_type, request_code, request_value,
//                                   request_index, request_length
//  output    out_valid / out_ready  response, reply_length, reply_first,
//                                   reply_second, address_load, device_address,
//                                   config_reset, descriptor_select,
//                                   descriptor_language, descriptor_limit
//
// One request per cycle sustained while out_ready stays high. An accepted request
// sits in the input register; the decode and state update load the result
// register when it is free or drains, and out_valid rises with that load.
// in_ready follows out_ready when both stages are full.
// arst_n clears both valid flags, the configuration, the alternate setting
// and all halt bits.
// ----------------------------------------------------------------------------
module usb_standard_request_responder
	import usbsrr_pkg::*;
#(
	parameter int ENDPOINT_COUNT  = 8,
	parameter int INTERFACE_COUNT = 2
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  request_type,
	input  logic [7:0]  request_code,
	input  logic [15:0] request_value,
	input  logic [15:0] request_index,
	input  logic [15:0] request_length,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  response,
	output logic [1:0]  reply_length,
	output logic [7:0]  reply_first,
	output logic [7:0]  reply_second,
	output logic        address_load,
	output logic [6:0]  device_address,
	output logic        config_reset,
	output logic [15:0] descriptor_select,
	output logic [15:0] descriptor_language,
	output logic [15:0] descriptor_limit
);

	localparam int EP_IDX_W = $clog2(ENDPOINT_COUNT);

	// Input stage
	logic        valid_s1;
	logic [7:0]  type_s1;
	logic [7:0]  code_s1;
	logic [15:0] value_s1;
	logic [15:0] index_s1;
	logic [15:0] length_s1;

	// Device state
	logic [7:0]                config_q;
	logic [7:0]                alt_q;
	logic [ENDPOINT_COUNT-1:0] in_halt_q;
	logic [ENDPOINT_COUNT-1:0] out_halt_q;

	// Result register
	logic    out_valid_q;
	result_t result_q;

	// Decode signals
	logic                      advance;
	logic [15:0]               key;
	logic [6:0]                ep;
	logic [EP_IDX_W-1:0]       ep_idx;
	logic                      ep_in;
	logic                      ep_ok;
	logic                      if_ok;
	logic                      halt_bit;
	result_t                   result_d;
	logic [7:0]                config_d;
	logic [7:0]                alt_d;
	logic [ENDPOINT_COUNT-1:0] in_halt_d;
	logic [ENDPOINT_COUNT-1:0] out_halt_d;

	// Move a request into the result register when it is free or drains
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Hold the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			type_s1   <= request_type;
			code_s1   <= request_code;
			value_s1  <= request_value;
			index_s1  <= request_index;
			length_s1 <= request_length;
		end
	end

	// Split the endpoint address out of wIndex
	assign key      = {code_s1, type_s1};
	assign ep       = index_s1[6:0] & EP_NUM_MASK;
	assign ep_idx   = ep[EP_IDX_W-1:0];
	assign ep_in    = index_s1[7];
	assign ep_ok    = ep < 7'(ENDPOINT_COUNT);
	assign if_ok    = index_s1 < 16'(INTERFACE_COUNT);
	assign halt_bit = ep_in ? in_halt_q[ep_idx] : out_halt_q[ep_idx];

	// Decode the request and work out the next device state
	always_comb begin
		result_d   = '0;
		config_d   = config_q;
		alt_d      = alt_q;
		in_halt_d  = in_halt_q;
		out_halt_d = out_halt_q;
		unique case (key) inside
			KEY_SET_ADDRESS: begin
				result_d.response       = RESP_ACK;
				result_d.address_load   = 1'b1;
				result_d.device_address = value_s1[6:0];
			end
			KEY_SET_CONFIG: begin
				config_d              = value_s1[7:0];
				in_halt_d             = in_halt_q & ENDPOINT_COUNT'(1);
				out_halt_d            = out_halt_q & ENDPOINT_COUNT'(1);
				result_d.response     = RESP_ACK;
				result_d.config_reset = 1'b1;
			end
			KEY_GET_CONFIG: begin
				result_d.response     = RESP_DATA;
				result_d.reply_length = LEN_ONE;
				result_d.reply_first  = config_q;
			end
			KEY_GET_STATUS_DEV: begin
				result_d.response     = RESP_DATA;
				result_d.reply_length = LEN_TWO;
			end
			KEY_GET_STATUS_EP: begin
				if (ep_ok) begin
					result_d.response     = RESP_DATA;
					result_d.reply_length = LEN_TWO;
					result_d.reply_first  = {7'd0, halt_bit};
				end
			end
			KEY_SET_FEATURE_EP, KEY_CLEAR_FEATURE: begin
				if (ep_ok) begin
					if (ep_in) begin
						in_halt_d[ep_idx] = (key == KEY_SET_FEATURE_EP);
					end else begin
						out_halt_d[ep_idx] = (key == KEY_SET_FEATURE_EP);
					end
					result_d.response = RESP_ACK;
				end
			end
			KEY_GET_DESC_DEV, KEY_GET_DESC_IF: begin
				result_d.response            = RESP_DESC;
				result_d.descriptor_select   = value_s1;
				result_d.descriptor_language = index_s1;
				result_d.descriptor_limit    = length_s1;
			end
			KEY_SET_INTERFACE: begin
				if (if_ok) begin
					alt_d             = value_s1[7:0];
					result_d.response = RESP_ACK;
				end
			end
			KEY_GET_INTERFACE: begin
				result_d.response     = RESP_DATA;
				result_d.reply_length = LEN_ONE;
				result_d.reply_first  = alt_q;
			end
			default: begin
				// unknown request: stall, nothing changes
				result_d = '0;
			end
		endcase
	end

	// Advance device state with the decoded request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			config_q   <= '0;
			alt_q      <= '0;
			in_halt_q  <= '0;
			out_halt_q <= '0;
		end else if (advance) begin
			config_q   <= config_d;
			alt_q      <= alt_d;
			in_halt_q  <= in_halt_d;
			out_halt_q <= out_halt_d;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	// Drive the result ports
	assign out_valid           = out_valid_q;
	assign response            = result_q.response;
	assign reply_length        = result_q.reply_length;
	assign reply_first         = result_q.reply_first;
	assign reply_second        = result_q.reply_second;
	assign address_load        = result_q.address_load;
	assign device_address      = result_q.device_address;
	assign config_reset        = result_q.config_reset;
	assign descriptor_select   = result_q.descriptor_select;
	assign descriptor_language = result_q.descriptor_language;
	assign descriptor_limit    = result_q.descriptor_limit;

	// Input stalls only when both stages are full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("in_ready low without a full, stalled pipeline");

	// Set configuration clears every halt bit but endpoint zero's
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && key == KEY_SET_CONFIG) |=>
		((in_halt_q >> 1) == '0 && (out_halt_q >> 1) == '0))
		else $error("halt bits survived set configuration");

	// Only a data reply carries reply bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && response != RESP_DATA) |->
		(reply_length == LEN_NONE && reply_first == 8'd0))
		else $error("reply bytes on a non-data response");

	// An address load always comes with a status ack
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && address_load) |-> (response == RESP_ACK && !config_reset))
		else $error("address load without a plain ack");

endmodule

// ===== test/usb_standard_request_responder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_standard_request_responder_tb
// Sends setup packets through the request channel, with a directed opening
// and a long random run. Every request is run through a scoreboard that
// tracks configuration, alternate setting and endpoint halts. Each response
// is checked field by field against the oldest expected response.
// ----------------------------------------------------------------------------
module usb_standard_request_responder_tb;
	import usbsrr_pkg::*;

	localparam int ENDPOINT_COUNT  = 8;
	localparam int INTERFACE_COUNT = 2;
	localparam int EP_IDX_W        = $clog2(ENDPOINT_COUNT);
	localparam int RANDOM_REQUESTS = 1900;
	localparam int HOLD_OFF_AFTER  = 400;
	localparam int HOLD_OFF_CYCLES = 300;

	// Keys that no standard request uses
	localparam logic [15:0] KEY_UNKNOWN_ONES = 16'hFFFF;
	localparam logic [15:0] KEY_UNKNOWN_ZERO = 16'h0000;

	typedef struct packed {
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] request_value;
		logic [15:0] request_index;
		logic [15:0] request_length;
	} setup_packet_t;

	typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_mode_t;

	// Device state copy and queue of responses still owed by the block
	class request_scoreboard;
		logic [7:0]                configuration;
		logic [7:0]                alternate;
		logic [ENDPOINT_COUNT-1:0] in_halt;
		logic [ENDPOINT_COUNT-1:0] out_halt;
		result_t                   pending_responses[$];
		int                        mismatches;

		function new();
			configuration = '0;
			alternate     = '0;
			in_halt       = '0;
			out_halt      = '0;
			mismatches    = 0;
		endfunction

		// Decode one accepted request, update the state, queue its response
		function void note_request(setup_packet_t p);
			logic [15:0]         key;
			logic [6:0]          ep;
			logic [EP_IDX_W-1:0] ep_idx;
			logic                is_in;
			result_t             e;
			key    = {p.request_code, p.request_type};
			ep     = p.request_index[6:0];
			ep_idx = ep[EP_IDX_W-1:0];
			is_in  = p.request_index[7];
			e      = '0;
			case (key)
				KEY_SET_ADDRESS: begin
					e.response       = RESP_ACK;
					e.address_load   = 1'b1;
					e.device_address = p.request_value[6:0];
				end
				KEY_SET_CONFIG: begin
					configuration = p.request_value[7:0];
					in_halt[ENDPOINT_COUNT-1:1]  = '0;
					out_halt[ENDPOINT_COUNT-1:1] = '0;
					e.response     = RESP_ACK;
					e.config_reset = 1'b1;
				end
				KEY_GET_CONFIG: begin
					e.response     = RESP_DATA;
					e.reply_length = LEN_ONE;
					e.reply_first  = configuration;
				end
				KEY_GET_STATUS_DEV: begin
					e.response     = RESP_DATA;
					e.reply_length = LEN_TWO;
				end
				KEY_GET_STATUS_EP: begin
					if (ep < ENDPOINT_COUNT) begin
						e.response     = RESP_DATA;
						e.reply_length = LEN_TWO;
						e.reply_first  = {7'd0, is_in ? in_halt[ep_idx] : out_halt[ep_idx]};
					end
				end
				KEY_SET_FEATURE_EP, KEY_CLEAR_FEATURE: begin
					// feature selector is ignored: always the endpoint halt
					if (ep < ENDPOINT_COUNT) begin
						if (is_in)
							in_halt[ep_idx] = (key == KEY_SET_FEATURE_EP);
						else
							out_halt[ep_idx] = (key == KEY_SET_FEATURE_EP);
						e.response = RESP_ACK;
					end
				end
				KEY_GET_DESC_DEV, KEY_GET_DESC_IF: begin
					e.response            = RESP_DESC;
					e.descriptor_select   = p.request_value;
					e.descriptor_language = p.request_index;
					e.descriptor_limit    = p.request_length;
				end
				KEY_SET_INTERFACE: begin
					if (p.request_index < INTERFACE_COUNT) begin
						alternate  = p.request_value[7:0];
						e.response = RESP_ACK;
					end
				end
				KEY_GET_INTERFACE: begin
					e.response     = RESP_DATA;
					e.reply_length = LEN_ONE;
					e.reply_first  = alternate;
				end
				default: ;
			endcase
			pending_responses.push_back(e);
		endfunction

		// Compare one response with the oldest pending one
		function void check_result(result_t got);
			result_t want;
			string   diffs;
			diffs = "";
			if (pending_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: response with no request pending: %h", $realtime, got);
				return;
			end
			want = pending_responses.pop_front();
			if (want.response !== got.response)
				diffs = {diffs, $sformatf(" response %h/%h", want.response, got.response)};
			if (want.reply_length !== got.reply_length)
				diffs = {diffs, $sformatf(" reply_length %h/%h",
					want.reply_length, got.reply_length)};
			if (want.reply_first !== got.reply_first)
				diffs = {diffs, $sformatf(" reply_first %h/%h",
					want.reply_first, got.reply_first)};
			if (want.reply_second !== got.reply_second)
				diffs = {diffs, $sformatf(" reply_second %h/%h",
					want.reply_second, got.reply_second)};
			if (want.address_load !== got.address_load)
				diffs = {diffs, $sformatf(" address_load %h/%h",
					want.address_load, got.address_load)};
			if (want.device_address !== got.device_address)
				diffs = {diffs, $sformatf(" device_address %h/%h",
					want.device_address, got.device_address)};
			if (want.config_reset !== got.config_reset)
				diffs = {diffs, $sformatf(" config_reset %h/%h",
					want.config_reset, got.config_reset)};
			if (want.descriptor_select !== got.descriptor_select)
				diffs = {diffs, $sformatf(" descriptor_select %h/%h",
					want.descriptor_select, got.descriptor_select)};
			if (want.descriptor_language !== got.descriptor_language)
				diffs = {diffs, $sformatf(" descriptor_language %h/%h",
					want.descriptor_language, got.descriptor_language)};
			if (want.descriptor_limit !== got.descriptor_limit)
				diffs = {diffs, $sformatf(" descriptor_limit %h/%h",
					want.descriptor_limit, got.descriptor_limit)};
			if (diffs != "") begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: response mismatch (expected/actual):%s", $realtime, diffs);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  request_type;
	logic [7:0]  request_code;
	logic [15:0] request_value;
	logic [15:0] request_index;
	logic [15:0] request_length;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  response;
	logic [1:0]  reply_length;
	logic [7:0]  reply_first;
	logic [7:0]  reply_second;
	logic        address_load;
	logic [6:0]  device_address;
	logic        config_reset;
	logic [15:0] descriptor_select;
	logic [15:0] descriptor_language;
	logic [15:0] descriptor_limit;

	request_scoreboard sb;
	int                accepted_count;

	usb_standard_request_responder #(
		.ENDPOINT_COUNT (ENDPOINT_COUNT),
		.INTERFACE_COUNT(INTERFACE_COUNT)
	) dut (.*);

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Generous run limit
	initial begin
		#2_000_000;
		$display("usb_standard_request_responder_tb NOT OK");
		$finish;
	end

	function automatic setup_packet_t make_request(logic [15:0] key, logic [15:0] value,
			logic [15:0] index, logic [15:0] length);
		setup_packet_t p;
		{p.request_code, p.request_type} = key;
		p.request_value  = value;
		p.request_index  = index;
		p.request_length = length;
		return p;
	endfunction

	// Standard keys, endpoint feature requests weighted up
	function automatic logic [15:0] known_key(int n);
		case (n)
			0:       return KEY_SET_ADDRESS;
			1:       return KEY_SET_CONFIG;
			2:       return KEY_GET_CONFIG;
			3:       return KEY_GET_STATUS_DEV;
			4:       return KEY_GET_STATUS_EP;
			5:       return KEY_CLEAR_FEATURE;
			6:       return KEY_GET_DESC_DEV;
			7:       return KEY_GET_DESC_IF;
			8:       return KEY_SET_INTERFACE;
			9:       return KEY_GET_INTERFACE;
			default: return KEY_SET_FEATURE_EP;
		endcase
	endfunction

	// Mostly standard requests aimed at valid targets, some corrupted keys, some noise
	function automatic setup_packet_t random_request();
		setup_packet_t p;
		logic [15:0]   key;
		int            pick;
		logic [3:0]    flip;
		pick = $urandom_range(0, 99);
		p.request_value  = 16'($urandom_range(0, 65535));
		p.request_index  = 16'($urandom_range(0, 65535));
		p.request_length = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3))
			: 16'($urandom_range(0, 65535));
		if (pick < 92) begin
			key = known_key($urandom_range(0, 12));
			case (key)
				KEY_GET_STATUS_EP, KEY_SET_FEATURE_EP, KEY_CLEAR_FEATURE: begin
					if ($urandom_range(0, 4) != 0) begin
						p.request_index[6:0] = 7'($urandom_range(0, ENDPOINT_COUNT - 1));
						if ($urandom_range(0, 3) != 0)
							p.request_index[15:8] = '0;
					end
				end
				KEY_SET_INTERFACE: begin
					if ($urandom_range(0, 3) != 0)
						p.request_index = 16'($urandom_range(0, INTERFACE_COUNT - 1));
					else if ($urandom_range(0, 1) != 0)
						p.request_index = 16'($urandom_range(INTERFACE_COUNT,
							INTERFACE_COUNT + 2));
				end
				default: ;
			endcase
			if (pick >= 84) begin
				flip = 4'($urandom_range(0, 15));
				key[flip] = ~key[flip];
			end
			{p.request_code, p.request_type} = key;
		end else begin
			p.request_type = 8'($urandom_range(0, 255));
			p.request_code = 8'($urandom_range(0, 255));
		end
		return p;
	endfunction

	// Offer one request and hold it until accepted; call and return at a falling edge
	task automatic send_request(setup_packet_t p);
		in_valid       <= 1'b1;
		request_type   <= p.request_type;
		request_code   <= p.request_code;
		request_value  <= p.request_value;
		request_index  <= p.request_index;
		request_length <= p.request_length;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic idle_sender(int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	// Track accepted requests and check responses
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_request('{request_type, request_code, request_value,
					request_index, request_length});
				accepted_count++;
			end
			if (out_valid && out_ready)
				sb.check_result('{response, reply_length, reply_first, reply_second,
					address_load, device_address, config_reset, descriptor_select,
					descriptor_language, descriptor_limit});
		end
	end

	// Response side: random stall phases plus one long hold-off
	initial begin
		ready_mode_t mode;
		int          phase_left;
		int          hold_left;
		bit          held_off;
		mode       = READY_ALWAYS;
		phase_left = 0;
		hold_left  = 0;
		held_off   = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && accepted_count >= HOLD_OFF_AFTER) begin
				held_off  = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					mode       = ready_mode_t'($urandom_range(0, 3));
					phase_left = $urandom_range(8, 80);
				end
				phase_left--;
				case (mode)
					READY_ALWAYS:   out_ready <= 1'b1;
					READY_HALF:     out_ready <= ($urandom_range(0, 1) != 0);
					READY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
					READY_PERIODIC: out_ready <= (phase_left % 5 != 0);
				endcase
			end
		end
	end

	// Request side: directed opening, then random bursts
	initial begin
		int sent;
		int burst;
		sb             = new();
		accepted_count = 0;
		sent           = 0;
		in_valid       = 1'b0;
		request_type   = '0;
		request_code   = '0;
		request_value  = '0;
		request_index  = '0;
		request_length = '0;
		@(posedge arst_n);
		@(negedge clk);

		// Reset values read back, field extremes, data replies not clipped
		send_request(make_request(KEY_GET_CONFIG, 16'h0000, 16'h0000, 16'h0000));
		send_request(make_request(KEY_GET_INTERFACE, 16'hFFFF, 16'hFFFF, 16'h0000));
		send_request(make_request(KEY_GET_STATUS_DEV, 16'hFFFF, 16'hFFFF, 16'h0001));
		send_request(make_request(KEY_SET_ADDRESS, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_request(make_request(KEY_SET_ADDRESS, 16'h0000, 16'h0000, 16'h0000));
		// Set halts; feature selector ignored, upper index byte ignored
		send_request(make_request(KEY_SET_FEATURE_EP, 16'hFFFF, 16'h0087, 16'h0000));
		send_request(make_request(KEY_SET_FEATURE_EP, 16'h0000, 16'h0000, 16'h0000));
		send_request(make_request(KEY_SET_FEATURE_EP, 16'h1234, 16'hFF03, 16'h0000));
		send_request(make_request(KEY_GET_STATUS_EP, 16'h0000, 16'h0087, 16'h0000));
		send_request(make_request(KEY_GET_STATUS_EP, 16'h0000, 16'h0007, 16'h0001));
		// Endpoints out of range stall
		send_request(make_request(KEY_GET_STATUS_EP, 16'h0000, 16'h0008, 16'h0002));
		send_request(make_request(KEY_SET_FEATURE_EP, 16'h0000, 16'h00FF, 16'h0000));
		send_request(make_request(KEY_CLEAR_FEATURE, 16'h0000, 16'h0088, 16'h0000));
		// Set configuration keeps only endpoint 0 halts
		send_request(make_request(KEY_SET_CONFIG, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_request(make_request(KEY_GET_CONFIG, 16'h0000, 16'h0000, 16'h0000));
		send_request(make_request(KEY_GET_STATUS_EP, 16'h0000, 16'h0000, 16'h0002));
		send_request(make_request(KEY_GET_STATUS_EP, 16'h0000, 16'h0087, 16'h0002));
		send_request(make_request(KEY_CLEAR_FEATURE, 16'hFFFF, 16'h0000, 16'h0000));
		// Interface range is checked on the whole index, not on get
		send_request(make_request(KEY_SET_INTERFACE, 16'hFFAB, 16'h0001, 16'h0000));
		send_request(make_request(KEY_SET_INTERFACE, 16'h0011, 16'h0002, 16'h0000));
		send_request(make_request(KEY_SET_INTERFACE, 16'h0022, 16'h0100, 16'h0000));
		send_request(make_request(KEY_GET_INTERFACE, 16'h0000, 16'h1234, 16'h0000));
		// Descriptor lookups and unknown requests
		send_request(make_request(KEY_GET_DESC_DEV, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_request(make_request(KEY_GET_DESC_IF, 16'h0000, 16'h0000, 16'h0000));
		send_request(make_request(KEY_UNKNOWN_ONES, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_request(make_request(KEY_UNKNOWN_ZERO, 16'h0000, 16'h0000, 16'h0000));

		// Random bursts with random gaps
		while (sent < RANDOM_REQUESTS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				send_request(random_request());
				sent++;
			end
			idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
		end
		in_valid <= 1'b0;

		// Drain, then allow for the pipeline latency
		while (sb.pending_responses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("usb_standard_request_responder_tb OK");
		else
			$display("usb_standard_request_responder_tb NOT OK");
		$finish;
	end

endmodule
